FILE: rtl/upper_triangular_back_substitution_unit_defines.svh
// ---------------------------------------------------------------------------
// Back-substitution unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i, reset on rst_ni.
// ---------------------------------------------------------------------------
`ifndef UPPER_TRIANGULAR_BACK_SUBSTITUTION_UNIT_DEFINES_SVH
`define UPPER_TRIANGULAR_BACK_SUBSTITUTION_UNIT_DEFINES_SVH

// same-cycle implication
`define UTBS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/utbs_pkg.sv
// ---------------------------------------------------------------------------
// Back-substitution unit package
// Sizes, register indexes and shared helpers.
// ---------------------------------------------------------------------------
package utbs_pkg;

  localparam int MaxUnk   = 8;
  localparam int FracBits = 24;
  localparam int DataW    = 48;
  localparam int Cols     = MaxUnk + 1;
  localparam int Depth    = MaxUnk * Cols;
  localparam int AddrW    = $clog2(Depth);
  localparam int IdxW     = $clog2(MaxUnk);
  localparam int CntW     = $clog2(MaxUnk + 1);
  localparam int SumW     = DataW + IdxW + 1;
  localparam int ThrW     = DataW - 1;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgUnknownCount   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPivotThreshold = CfgIdxW'(1);

  typedef logic signed [DataW-1:0] word_t;

  function automatic logic [DataW-1:0] magnitude(word_t v);
    return v[DataW-1] ? DataW'(-v) : DataW'(v);
  endfunction

endpackage

FILE: rtl/upper_triangular_back_substitution_unit.sv
// ---------------------------------------------------------------------------
// Upper-triangular back-substitution unit
// Loads an augmented matrix word by word, then checks pivots, normalizes
// rows and back-substitutes into a chain of solution cells.
//
// Input channel: one matrix entry per word (row, column, Q24.24 value).
// Column equal to unknown_count (clamped to 2..8) is the right-hand side.
// Loading takes a word on each in_valid_i while idle; the end_of_load word
// starts the solve; in_stall_o stays high until the last result is taken.
// Config channel: cfg_ready_o is always high; write only while idle.
// Solve steps: a pivot check of the n diagonal entries; each normalized entry
// goes through the bit-serial divider (n(n+3)/2 entries); each product goes
// through the four-step multiplier; then n result words.
// A singular system gives one word: index 0, value 0, singular, last.
// Output words sit in a register; out_stall_i holds the word and the solve.
// Reset returns the registers to n=2, threshold 17; matrix contents are
// undefined until written.
// ---------------------------------------------------------------------------
module upper_triangular_back_substitution_unit
  import utbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         row_index_i,
  input  logic [3:0]         column_index_i,
  input  logic signed [47:0] coefficient_i,
  input  logic               end_of_load_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         unknown_index_o,
  output logic signed [47:0] solution_o,
  output logic               singular_o,
  output logic               last_result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ThrW-1:0]    cfg_data_i
);

`include "upper_triangular_back_substitution_unit_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_RD, S_CHK_EV, S_DIV_P, S_DIV_PW, S_DIV_RD, S_DIV_LD, S_DIV_RUN,
    S_BS_RD, S_BS_DAT, S_BS_MUL, S_OUT
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     ucount_q, n_q, j_q;
  logic [ThrW-1:0]     thr_q;
  logic [IdxW-1:0]     k_q;
  word_t               piv_q;
  logic signed [SumW-1:0] s_q;
  logic                sing_q;
  logic                out_valid_q, out_sing_q, out_last_q;
  logic [IdxW-1:0]     out_idx_q;
  word_t               out_sol_q;

  word_t               mem [Depth];
  word_t               rd_data_q;
  logic [AddrW-1:0]    rd_addr, wr_addr;
  logic                we;
  word_t               wr_data;

  logic                div_start, div_done, mul_start, mul_done;
  word_t               div_q, mul_p;
  word_t               cell_q [MaxUnk];
  logic                shift;
  word_t               x_new;
  logic signed [SumW-1:0] diff;
  logic [CntW-1:0]     sel;
  logic [CntW-1:0]     n_eff;
  logic                bad;

  function automatic logic [AddrW-1:0] addr(logic [IdxW-1:0] r, logic [CntW-1:0] c);
    return AddrW'(int'(r) * Cols + int'(c));
  endfunction

  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (ucount_q < CntW'(2)) n_eff = CntW'(2);
    else if (ucount_q > CntW'(MaxUnk)) n_eff = CntW'(MaxUnk);
    else n_eff = ucount_q;
  end

  always_comb begin
    unique case (state_q)
      S_CHK_RD, S_DIV_P: rd_addr = addr(k_q, CntW'(k_q));
      default:           rd_addr = addr(k_q, j_q);
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = addr(k_q, j_q);
    wr_data = div_q;
    if (state_q == S_IDLE) begin
      wr_addr = addr(row_index_i, column_index_i);
      wr_data = coefficient_i;
      we      = in_valid_i && CntW'(row_index_i) < CntW'(MaxUnk)
                && column_index_i <= CntW'(MaxUnk);
    end else if (state_q == S_DIV_RUN) begin
      we = div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign bad = rd_data_q == '0 || magnitude(rd_data_q) < {1'b0, thr_q};

  assign div_start = state_q == S_DIV_LD;
  assign mul_start = state_q == S_BS_DAT && j_q != n_q;
  assign sel       = j_q - CntW'(k_q) - CntW'(1);
  assign diff      = SumW'(rd_data_q) - s_q;
  assign x_new     = (diff[SumW-1:DataW-1] == '0 || diff[SumW-1:DataW-1] == '1)
                     ? diff[DataW-1:0]
                     : (diff[SumW-1] ? {1'b1, {(DataW-1){1'b0}}}
                                     : {1'b0, {(DataW-1){1'b1}}});
  assign shift     = state_q == S_BS_DAT && j_q == n_q;

  utbs_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(rd_data_q), .den_i(piv_q),
    .done_o(div_done), .q_o(div_q)
  );

  utbs_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(rd_data_q), .b_i(cell_q[sel[IdxW-1:0]]),
    .done_o(mul_done), .p_o(mul_p)
  );

  for (genvar g = 0; g < MaxUnk; g++) begin : g_cell
    if (g == 0) begin : g_head
      utbs_cell u_cell (.clk_i, .shift_i(shift), .d_i(x_new), .q_o(cell_q[g]));
    end else begin : g_body
      utbs_cell u_cell (.clk_i, .shift_i(shift), .d_i(cell_q[g-1]), .q_o(cell_q[g]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ucount_q    <= CntW'(2);
      thr_q       <= ThrW'(17);
      n_q         <= CntW'(2);
      k_q         <= '0;
      j_q         <= '0;
      piv_q       <= '0;
      s_q         <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_sing_q  <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_sol_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgUnknownCount) ucount_q <= cfg_data_i[CntW-1:0];
        else if (cfg_index_i == CfgPivotThreshold) thr_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && end_of_load_i) begin
            n_q     <= n_eff;
            k_q     <= '0;
            sing_q  <= 1'b0;
            state_q <= S_CHK_RD;
          end
        end
        S_CHK_RD: state_q <= S_CHK_EV;
        S_CHK_EV: begin
          if (CntW'(k_q) == n_q - CntW'(1)) begin
            k_q <= '0;
            if (sing_q || bad) begin
              out_valid_q <= 1'b1;
              out_idx_q   <= '0;
              out_sol_q   <= '0;
              out_sing_q  <= 1'b1;
              out_last_q  <= 1'b1;
              state_q     <= S_OUT;
            end else begin
              state_q <= S_DIV_P;
            end
          end else begin
            sing_q  <= sing_q | bad;
            k_q     <= k_q + IdxW'(1);
            state_q <= S_CHK_RD;
          end
        end
        S_DIV_P:  state_q <= S_DIV_PW;
        S_DIV_PW: begin
          piv_q   <= rd_data_q;
          j_q     <= CntW'(k_q);
          state_q <= S_DIV_RD;
        end
        S_DIV_RD: state_q <= S_DIV_LD;
        S_DIV_LD: state_q <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (div_done) begin
            if (j_q == n_q) begin
              if (CntW'(k_q) == n_q - CntW'(1)) begin
                j_q     <= n_q;
                s_q     <= '0;
                state_q <= S_BS_RD;
              end else begin
                k_q     <= k_q + IdxW'(1);
                state_q <= S_DIV_P;
              end
            end else begin
              j_q     <= j_q + CntW'(1);
              state_q <= S_DIV_RD;
            end
          end
        end
        S_BS_RD: state_q <= S_BS_DAT;
        S_BS_DAT: begin
          if (j_q == n_q) begin
            if (k_q == '0) begin
              out_valid_q <= 1'b1;
              out_idx_q   <= '0;
              out_sol_q   <= x_new;
              out_sing_q  <= 1'b0;
              out_last_q  <= 1'b0;
              state_q     <= S_OUT;
            end else begin
              j_q     <= CntW'(k_q);
              k_q     <= k_q - IdxW'(1);
              s_q     <= '0;
              state_q <= S_BS_RD;
            end
          end else begin
            state_q <= S_BS_MUL;
          end
        end
        S_BS_MUL: begin
          if (mul_done) begin
            s_q     <= s_q + SumW'(mul_p);
            j_q     <= j_q + CntW'(1);
            state_q <= S_BS_RD;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            if (out_last_q) begin
              out_valid_q <= 1'b0;
              state_q     <= S_IDLE;
            end else begin
              out_idx_q  <= out_idx_q + IdxW'(1);
              out_sol_q  <= cell_q[out_idx_q + IdxW'(1)];
              out_last_q <= CntW'(out_idx_q) + CntW'(1) == n_q - CntW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign unknown_index_o = out_idx_q;
  assign solution_o      = out_sol_q;
  assign singular_o      = out_sing_q;
  assign last_result_o   = out_last_q;

  `UTBS_ASSERT(a_no_accept_busy, !in_stall_o, !out_valid_o, "input taken while results pending")
  `UTBS_ASSERT(a_sing_word, out_valid_o && singular_o,
               last_result_o && solution_o == '0 && unknown_index_o == '0,
               "malformed singular word")
  `UTBS_ASSERT(a_last_index, out_valid_o && last_result_o && !singular_o,
               CntW'(unknown_index_o) == n_q - CntW'(1), "last word at wrong index")
  `UTBS_ASSERT_NEXT(a_done_idle, out_valid_o && last_result_o && !out_stall_i,
                    !out_valid_o && !in_stall_o, "no return to idle after last word")

endmodule

FILE: rtl/utbs_cell.sv
// ---------------------------------------------------------------------------
// Solution cell
// One stage of the solution chain; takes its neighbor's word on shift.
// ---------------------------------------------------------------------------
module utbs_cell
  import utbs_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  word_t d_i,
  output word_t q_o
);

  word_t val_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

FILE: rtl/utbs_div.sv
// ---------------------------------------------------------------------------
// Fixed-point divider
// Restoring radix-2 divide of (num * 2^F) / den, truncated, saturated.
// ---------------------------------------------------------------------------
module utbs_div
  import utbs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t num_i,
  input  word_t den_i,
  output logic  done_o,
  output word_t q_o
);

  localparam int DvdW = DataW + FracBits;
  localparam int StW  = $clog2(DvdW);

  logic [DvdW-1:0]  dvd_q;
  logic [DataW-1:0] ud_q, r_q, quo_q;
  logic [StW-1:0]   cnt_q;
  logic             busy_q, fin_q, over_q, neg_q, done_q;
  word_t            q_q;

  logic [DataW-1:0] rs, lim, qsat;
  logic             ge;

  always_comb begin
    rs   = {r_q[DataW-2:0], dvd_q[DvdW-1]};
    ge   = rs >= ud_q;
    lim  = neg_q ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    qsat = (over_q || quo_q > lim) ? lim : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      ud_q   <= '0;
      r_q    <= '0;
      quo_q  <= '0;
      over_q <= 1'b0;
      neg_q  <= 1'b0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= StW'(DvdW - 1);
        dvd_q  <= {magnitude(num_i), {FracBits{1'b0}}};
        ud_q   <= magnitude(den_i);
        r_q    <= '0;
        quo_q  <= '0;
        over_q <= 1'b0;
        neg_q  <= num_i[DataW-1] != den_i[DataW-1];
      end else if (busy_q) begin
        r_q    <= ge ? rs - ud_q : rs;
        quo_q  <= {quo_q[DataW-2:0], ge};
        over_q <= over_q | quo_q[DataW-1];
        dvd_q  <= {dvd_q[DvdW-2:0], 1'b0};
        cnt_q  <= cnt_q - StW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        q_q    <= neg_q ? DataW'(-qsat) : qsat;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

FILE: rtl/utbs_mul.sv
// ---------------------------------------------------------------------------
// Fixed-point multiplier
// Four half-width partial products, floored by F bits, saturated.
// ---------------------------------------------------------------------------
module utbs_mul
  import utbs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t a_i,
  input  word_t b_i,
  output logic  done_o,
  output word_t p_o
);

  localparam int HalfW = DataW / 2;
  localparam int ProdW = 2 * DataW;
  localparam int TW    = ProdW - FracBits;

  logic [DataW-1:0] ua_q, ub_q;
  logic [ProdW-1:0] acc_q;
  logic [2:0]       step_q;
  logic             busy_q, neg_q, done_q;
  word_t            p_q;

  logic [HalfW-1:0] ah, bh;
  logic [DataW-1:0] pp;
  logic [ProdW-1:0] pp_sh;
  logic [TW-1:0]    t, lim;
  logic [DataW-1:0] qsat;

  always_comb begin
    ah    = step_q[0] ? ua_q[DataW-1:HalfW] : ua_q[HalfW-1:0];
    bh    = step_q[1] ? ub_q[DataW-1:HalfW] : ub_q[HalfW-1:0];
    pp    = DataW'(ah) * DataW'(bh);
    pp_sh = ProdW'(pp) << (HalfW * (int'(step_q[0]) + int'(step_q[1])));
    t     = acc_q[ProdW-1:FracBits] + TW'(neg_q && acc_q[FracBits-1:0] != '0);
    lim   = neg_q ? (TW'(1) << (DataW - 1)) : ((TW'(1) << (DataW - 1)) - TW'(1));
    qsat  = (t > lim) ? lim[DataW-1:0] : t[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      ua_q   <= '0;
      ub_q   <= '0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      p_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        ua_q   <= magnitude(a_i);
        ub_q   <= magnitude(b_i);
        acc_q  <= '0;
        neg_q  <= a_i[DataW-1] != b_i[DataW-1];
      end else if (busy_q) begin
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          p_q    <= neg_q ? DataW'(-qsat) : qsat;
        end else begin
          acc_q  <= acc_q + pp_sh;
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule
